// ===== sv/tva_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and codes of the tree vector to ancestry block
package tva_pkg;

  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int CODE_W           = 6;
  localparam int LABEL_W          = 7;

  // one element of the tree vector
  typedef struct packed {
    logic [CODE_W-1:0] leaf_code;
    logic              is_last;
  } vec_item_t;

  // one ancestry result
  typedef struct packed {
    logic [LABEL_W-1:0] parent_label;
    logic [LABEL_W-1:0] first_child;
    logic [LABEL_W-1:0] second_child;
    logic               final_triplet;
    logic               error;
  } trip_item_t;

  // stored triplet of one merge step
  typedef struct packed {
    logic [LABEL_W-1:0] parent;
    logic [LABEL_W-1:0] kid_a;
    logic [LABEL_W-1:0] kid_b;
  } trip_rec_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_OLD_RD,
    ST_OLD_CAP,
    ST_KID_RD,
    ST_KID_CAP,
    ST_UPD,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } state_t;

  // operations of the shared compare and increment unit
  typedef enum logic [1:0] {
    ALU_LE,
    ALU_EQ,
    ALU_INC
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [LABEL_W-1:0] a;
    logic [LABEL_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               hit;
    logic [LABEL_W-1:0] sum;
  } alu_rsp_t;

endpackage

// ===== sv/tree_vector_to_ancestry_core.sv =====
`timescale 1ns / 1ps
// Tree code vector to ancestry triplets.
// The vector channel (vec_valid, vec_stall, vec_item) takes one element per
// item; the item flagged is_last closes the vector and starts a run. While
// elements load, vec_stall is low and each item is taken in the cycle that it
// is offered. A run of k elements first sweeps the view matrix memory, then
// runs k merge steps, each a row scan, a column search through the registered
// view read port, a read and capture of the old label and of the child label
// on the label memory, and row updates; all compares and increments go
// through one shared unit. The k triplets then leave on the result channel
// (trip_valid, trip_stall, trip_item) in reverse step order; the last carries
// final_triplet. vec_stall stays high from the last element until the final
// result is taken. An invalid element, an overlong vector or a label that is
// not found gives one error item with final_triplet set instead.
// Reset (rst, synchronous) empties the vector and drops any run in flight.
// While trip_stall is high the result item holds and the block waits.
module tree_vector_to_ancestry_core import tva_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       vec_valid,
  output logic       vec_stall,
  input  vec_item_t  vec_item,
  output logic       trip_valid,
  input  logic       trip_stall,
  output trip_item_t trip_item
);

  localparam int IDX_W      = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int CNT_W      = $clog2(MAX_CODE_LEN + 1);
  localparam int VIEW_DEPTH = 1 << (2 * IDX_W);
  localparam int CMP_W      = CODE_W + CNT_W + 1;

  state_t state, state_next;

  logic [CNT_W-1:0]   loaded_count;
  logic               invalid_seen;
  logic [CNT_W-1:0]   cnt_next;
  logic               inv_next;

  logic [CNT_W-1:0]   run_len;
  logic [IDX_W-1:0]   run_last;
  logic [IDX_W-1:0]   ri;
  logic [CNT_W-1:0]   col;
  logic [IDX_W-1:0]   node;
  logic [IDX_W-1:0]   match_col;
  logic [IDX_W-1:0]   step;
  logic [LABEL_W-1:0] next_label;
  logic [LABEL_W-1:0] old_label;

  logic [CODE_W-1:0]       code_store [0:MAX_CODE_LEN-1];
  logic [LABEL_W-1:0]      row_max    [0:MAX_CODE_LEN-1];
  logic [MAX_CODE_LEN-1:0] done_marks;

  logic [LABEL_W-1:0]   view_mem [0:VIEW_DEPTH-1];
  logic                 view_we;
  logic [2*IDX_W-1:0]   view_waddr;
  logic [2*IDX_W-1:0]   view_raddr;
  logic [LABEL_W-1:0]   view_wdata;
  logic [LABEL_W-1:0]   view_rdata;

  logic [LABEL_W-1:0]   cl_mem [0:MAX_CODE_LEN];
  logic                 cl_we;
  logic [CNT_W-1:0]     cl_waddr;
  logic [CNT_W-1:0]     cl_raddr;
  logic [LABEL_W-1:0]   cl_wdata;
  logic [LABEL_W-1:0]   cl_rdata;

  trip_rec_t            trip_mem [0:MAX_CODE_LEN-1];
  logic                 trip_we;
  trip_rec_t            trip_wdata;
  trip_rec_t            trip_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [CODE_W-1:0] cur_code;
  logic              out_take;
  logic              cand_hit;

  assign cur_code = code_store[ri];
  assign out_take = trip_valid && !trip_stall;
  assign cand_hit = alu_rsp.hit && !done_marks[ri];

  // shared compare and increment unit
  tva_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // length and validity after the element on the vector channel
  always_comb begin
    cnt_next = loaded_count;
    inv_next = invalid_seen;
    if (loaded_count < CNT_W'(MAX_CODE_LEN)) begin
      cnt_next = loaded_count + CNT_W'(1);
      if (CMP_W'(vec_item.leaf_code) > CMP_W'({loaded_count, 1'b0})) begin
        inv_next = 1'b1;
      end
    end else begin
      inv_next = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (vec_valid && vec_item.is_last) begin
          state_next = inv_next ? ST_OUT_WAIT : ST_INIT;
        end
      end
      ST_INIT: begin
        if (col == run_len && ri == run_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cand_hit || ri == '0) begin
          state_next = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        state_next = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (alu_rsp.hit) begin
          state_next = ST_OLD_RD;
        end else if (col == CNT_W'(run_last)) begin
          state_next = ST_OUT_WAIT;
        end else begin
          state_next = ST_SRCH_RD;
        end
      end
      ST_OLD_RD:  state_next = ST_OLD_CAP;
      ST_OLD_CAP: state_next = ST_KID_RD;
      ST_KID_RD:  state_next = ST_KID_CAP;
      ST_KID_CAP: state_next = ST_UPD;
      ST_UPD: begin
        if (ri == run_last) begin
          state_next = (step == run_last) ? ST_OUT_RD : ST_SCAN;
        end
      end
      ST_OUT_RD:   state_next = ST_OUT_LOAD;
      ST_OUT_LOAD: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_take) begin
          state_next = trip_item.final_triplet ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: shared unit request, memory ports, vector stall
  always_comb begin
    vec_stall   = 1'b1;
    alu_req.op  = ALU_EQ;
    alu_req.a   = '0;
    alu_req.b   = '0;
    view_we     = 1'b0;
    view_waddr  = {ri, col[IDX_W-1:0]};
    view_raddr  = {ri, col[IDX_W-1:0]};
    view_wdata  = '0;
    cl_we       = 1'b0;
    cl_waddr    = col;
    cl_raddr    = CNT_W'(match_col);
    cl_wdata    = LABEL_W'(col);
    trip_we     = 1'b0;
    trip_wdata.parent = next_label;
    trip_wdata.kid_a  = cl_rdata;
    trip_wdata.kid_b  = old_label;
    case (state)
      ST_IDLE: begin
        vec_stall = 1'b0;
      end
      ST_INIT: begin
        alu_req.op = ALU_LE;
        alu_req.a  = LABEL_W'(col);
        alu_req.b  = LABEL_W'(ri);
        view_we    = (col != run_len);
        view_wdata = alu_rsp.hit ? LABEL_W'(col) : '0;
        cl_we      = (ri == '0);
      end
      ST_SCAN: begin
        alu_req.op = ALU_LE;
        alu_req.a  = LABEL_W'(cur_code);
        alu_req.b  = row_max[ri];
      end
      ST_SRCH_CMP: begin
        alu_req.op = ALU_EQ;
        alu_req.a  = view_rdata;
        alu_req.b  = LABEL_W'(cur_code);
      end
      ST_OLD_RD: begin
        cl_raddr = CNT_W'(match_col);
      end
      ST_OLD_CAP: begin
        cl_we    = 1'b1;
        cl_waddr = CNT_W'(match_col);
        cl_wdata = next_label;
      end
      ST_KID_RD: begin
        cl_raddr = CNT_W'(node) + CNT_W'(1);
      end
      ST_KID_CAP: begin
        trip_we = 1'b1;
      end
      ST_UPD: begin
        alu_req.op = ALU_INC;
        alu_req.a  = row_max[ri];
        view_we    = 1'b1;
        view_waddr = {ri, match_col};
        view_wdata = alu_rsp.sum;
      end
      default: begin
        vec_stall = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      loaded_count <= '0;
      invalid_seen <= 1'b0;
      trip_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      trip_valid <= (state_next == ST_OUT_WAIT);
      if (state == ST_IDLE && vec_valid) begin
        loaded_count <= vec_item.is_last ? '0 : cnt_next;
        invalid_seen <= vec_item.is_last ? 1'b0 : inv_next;
      end
    end
  end

  // datapath registers and small stores
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (vec_valid) begin
          if (loaded_count < CNT_W'(MAX_CODE_LEN)) begin
            code_store[loaded_count[IDX_W-1:0]] <= vec_item.leaf_code;
          end
          if (vec_item.is_last) begin
            run_len    <= cnt_next;
            run_last   <= IDX_W'(cnt_next - CNT_W'(1));
            ri         <= '0;
            col        <= '0;
            done_marks <= '0;
            for (int i = 0; i < MAX_CODE_LEN; i++) begin
              row_max[i] <= LABEL_W'(i);
            end
            step      <= '0;
            trip_item <= '{parent_label: '0, first_child: '0, second_child: '0,
                           final_triplet: 1'b1, error: 1'b1};
          end
        end
      end
      ST_INIT: begin
        if (col == run_len) begin
          col <= '0;
          if (ri == run_last) begin
            step       <= '0;
            next_label <= LABEL_W'(run_len) + LABEL_W'(1);
          end else begin
            ri <= ri + IDX_W'(1);
          end
        end else begin
          col <= col + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        col <= '0;
        if (cand_hit) begin
          node <= ri;
        end else if (ri == '0) begin
          node <= run_last;
          ri   <= run_last;
        end else begin
          ri <= ri - IDX_W'(1);
        end
      end
      ST_SRCH_CMP: begin
        if (alu_rsp.hit) begin
          match_col <= col[IDX_W-1:0];
        end else if (col == CNT_W'(run_last)) begin
          step      <= '0;
          trip_item <= '{parent_label: '0, first_child: '0, second_child: '0,
                         final_triplet: 1'b1, error: 1'b1};
        end else begin
          col <= col + CNT_W'(1);
        end
      end
      ST_OLD_CAP: begin
        old_label <= cl_rdata;
      end
      ST_KID_CAP: begin
        done_marks[node] <= 1'b1;
        ri               <= node;
      end
      ST_UPD: begin
        row_max[ri] <= alu_rsp.sum;
        if (ri == run_last) begin
          if (step != run_last) begin
            step       <= step + IDX_W'(1);
            next_label <= next_label + LABEL_W'(1);
          end
        end else begin
          ri <= ri + IDX_W'(1);
        end
      end
      ST_OUT_LOAD: begin
        trip_item <= '{parent_label: trip_rdata.parent,
                       first_child: trip_rdata.kid_a,
                       second_child: trip_rdata.kid_b,
                       final_triplet: (step == '0), error: 1'b0};
      end
      ST_OUT_WAIT: begin
        if (out_take && !trip_item.final_triplet) begin
          step <= step - IDX_W'(1);
        end
      end
      default: begin
        old_label <= old_label;
      end
    endcase
  end

  // view matrix memory, registered read
  always_ff @(posedge clk) begin
    if (view_we) begin
      view_mem[view_waddr] <= view_wdata;
    end
    view_rdata <= view_mem[view_raddr];
  end

  // current label memory, registered read
  always_ff @(posedge clk) begin
    if (cl_we) begin
      cl_mem[cl_waddr] <= cl_wdata;
    end
    cl_rdata <= cl_mem[cl_raddr];
  end

  // triplet memory, read back in reverse step order
  always_ff @(posedge clk) begin
    if (trip_we) begin
      trip_mem[step] <= trip_wdata;
    end
    trip_rdata <= trip_mem[step];
  end

endmodule

// ===== sv/tva_alu.sv =====
`timescale 1ns / 1ps
// shared compare and increment unit used by the init, scan, search and update phases of the sequencer
module tva_alu import tva_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  // one operation per cycle, chosen by the sequencer
  always_comb begin
    rsp.hit = 1'b0;
    rsp.sum = req.a;
    case (req.op)
      ALU_LE: begin
        rsp.hit = (req.a <= req.b);
      end
      ALU_EQ: begin
        rsp.hit = (req.a == req.b);
      end
      ALU_INC: begin
        rsp.sum = req.a + LABEL_W'(1);
      end
      default: begin
        rsp.hit = 1'b0;
        rsp.sum = req.a;
      end
    endcase
  end

endmodule

// ===== sv/tva_checker.sv =====
`timescale 1ns / 1ps
// port-level checks on the tree vector to ancestry block, bound to the top level
module tva_checker import tva_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       vec_valid,
  input logic       vec_stall,
  input vec_item_t  vec_item,
  input logic       trip_valid,
  input logic       trip_stall,
  input trip_item_t trip_item
);

  // no vector item is taken while a result is on offer
  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    trip_valid |-> vec_stall)
    else $error("vector item taken while a result item is pending");

  // an element that does not close the vector leaves the block ready
  a_ready_after_elem: assert property (@(posedge clk) disable iff (rst)
    (vec_valid && !vec_stall && !vec_item.is_last) |=> !vec_stall)
    else $error("block not ready after a non-final element");

  // an error item is the last of its run and carries no labels
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (trip_valid && trip_item.error) |->
      (trip_item.final_triplet && trip_item.parent_label == '0 &&
       trip_item.first_child == '0 && trip_item.second_child == '0))
    else $error("malformed error item");

  // a merge result always names a fresh internal node
  a_parent_nonzero: assert property (@(posedge clk) disable iff (rst)
    (trip_valid && !trip_item.error) |-> (trip_item.parent_label != '0))
    else $error("merge result with a zero parent label");

  // a stalled result item holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (trip_valid && trip_stall) |=> (trip_valid && $stable(trip_item)))
    else $error("stalled result item changed or dropped");

endmodule

bind tree_vector_to_ancestry_core tva_checker u_tva_checker (.*);
